>>> src/efd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_pkg: shared types and constants of the escaped frame deframer
// Phase codes, result codes, register indexes and the channel payload types.
// ----------------------------------------------------------------------------
package efd_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLYNOMIAL  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CRC_INITIAL     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_LEADER   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_FOR_FF     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_FOR_LEADER = 3'd4;

  // Register reset values.
  localparam logic [15:0] RST_CRC_POLYNOMIAL  = 16'h1021;
  localparam logic [15:0] RST_CRC_INITIAL     = 16'hFFFF;
  localparam logic [7:0]  RST_ESCAPE_LEADER   = 8'hFE;
  localparam logic [7:0]  RST_CODE_FOR_FF     = 8'h01;
  localparam logic [7:0]  RST_CODE_FOR_LEADER = 8'h02;

  localparam logic [7:0]  SYNC_BYTE = 8'hFF;

  // Parser phases.
  localparam logic [3:0] PH_HUNT1   = 4'd0;
  localparam logic [3:0] PH_HUNT2   = 4'd1;
  localparam logic [3:0] PH_TYPE    = 4'd2;
  localparam logic [3:0] PH_SEQ_HI  = 4'd3;
  localparam logic [3:0] PH_SEQ_LO  = 4'd4;
  localparam logic [3:0] PH_LEN_HI  = 4'd5;
  localparam logic [3:0] PH_LEN_LO  = 4'd6;
  localparam logic [3:0] PH_PAYLOAD = 4'd7;
  localparam logic [3:0] PH_CRC_HI  = 4'd8;
  localparam logic [3:0] PH_CRC_LO  = 4'd9;

  // Result kinds and frame status codes.
  localparam logic       KIND_DATA  = 1'b0;
  localparam logic       KIND_END   = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC_BAD = 2'd1;
  localparam logic [1:0] ST_ESC_ERR = 2'd2;

  typedef struct packed {
    logic [15:0] crc_polynomial;
    logic [15:0] crc_initial;
    logic [7:0]  escape_leader;
    logic [7:0]  code_for_ff;
    logic [7:0]  code_for_leader;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  frame_type;
    logic [15:0] sequence_res;
    logic [15:0] payload_length;
    logic [15:0] received_crc;
    logic [1:0]  status;
  } result_t;

endpackage

>>> src/efd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_if: channel interfaces of the escaped frame deframer
// Received byte channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface efd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efd_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [7:0]  frame_type;
  logic [15:0] sequence_res;
  logic [15:0] payload_length;
  logic [15:0] received_crc;
  logic [1:0]  status;
  modport source (output valid, output kind, output data_byte, output frame_type,
                  output sequence_res, output payload_length, output received_crc,
                  output status, input ready);
  modport sink   (input valid, input kind, input data_byte, input frame_type,
                  input sequence_res, input payload_length, input received_crc,
                  input status, output ready);
endinterface

interface efd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [efd_pkg::CFG_INDEX_W-1:0]    index;
  logic [efd_pkg::CFG_DATA_W-1:0]     wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> src/escaped_frame_deframer_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_deframer_crc16: byte-stuffed frame receiver with CRC16 check
// Finds 0xFF 0xFF sync, reads the header, unescapes payload and trailer and
// reports every payload byte and a frame end status.
// ----------------------------------------------------------------------------
// Usage:
//   rx  carries one raw link byte per word (valid/ready).
//   res carries result words: a decoded payload byte (kind 0) or a frame end
//       report (kind 1) with status ok, CRC mismatch or invalid escape.
//       Header fields of the current frame ride along on every word.
//   cfg writes the five configuration registers; it is always ready, and is
//       to be used only while no byte is in flight.
// Timing: a byte is taken into an input register; when the parser steps it
//   updates its state and loads any result word into the output register,
//   from which the word is offered on res.
//   One byte per cycle is sustained while res does not hold off a result
//   word; the CRC update of a whole byte is combinational within the
//   parser step.
// Reset: synchronous; the block hunts for sync, registers return to their
//   default settings and both the input and output registers empty.
// Stall: while the receiver holds off a pending result word, the parser
//   waits and one more byte is held in the input register before rx.ready
//   drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module escaped_frame_deframer_crc16 (
  input  logic       clk,
  input  logic       rst,
  efd_rx_if.sink     rx,
  efd_res_if.source  res,
  efd_cfg_if.sink    cfg
);

  efd_pkg::cfg_t    regs;
  efd_pkg::result_t p_res;
  efd_pkg::result_t out_word;
  logic             p_valid;
  logic             in_valid;
  logic [7:0]       in_byte;
  logic             out_valid;
  logic             advance;
  logic             step;

  efd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // The parser may move only when its result has a free place to go.
  assign advance  = !out_valid || res.ready;
  assign step     = in_valid && advance;
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) in_byte <= rx.rx_byte;
  end

  efd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (in_byte),
    .regs      (regs),
    .res_valid (p_valid),
    .res       (p_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && p_valid) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && p_valid) out_word <= p_res;
  end

  assign res.valid          = out_valid;
  assign res.kind           = out_word.kind;
  assign res.data_byte      = out_word.data_byte;
  assign res.frame_type     = out_word.frame_type;
  assign res.sequence_res   = out_word.sequence_res;
  assign res.payload_length = out_word.payload_length;
  assign res.received_crc   = out_word.received_crc;
  assign res.status         = out_word.status;

  // An empty input register always takes a new byte.
  a_rx_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> rx.ready)
    else $error("input register empty but rx not ready");

  // A byte held back by a stalled output stays in the input register.
  a_held_byte_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("stalled byte lost from input register");

  // Only frame end reports carry a nonzero status.
  a_status_on_end: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status != efd_pkg::ST_OK |-> res.kind == efd_pkg::KIND_END)
    else $error("nonzero status on a payload word");

  // The output register is empty right after reset.
  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res.valid)
    else $error("result valid right after reset");

endmodule

>>> src/efd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_cfg_regs: configuration register file
// Holds CRC polynomial, CRC initial value and the escape settings.
// ----------------------------------------------------------------------------
module efd_cfg_regs (
  input  logic         clk,
  input  logic         rst,
  efd_cfg_if.sink      cfg,
  output efd_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.crc_polynomial  <= efd_pkg::RST_CRC_POLYNOMIAL;
      regs.crc_initial     <= efd_pkg::RST_CRC_INITIAL;
      regs.escape_leader   <= efd_pkg::RST_ESCAPE_LEADER;
      regs.code_for_ff     <= efd_pkg::RST_CODE_FOR_FF;
      regs.code_for_leader <= efd_pkg::RST_CODE_FOR_LEADER;
    end else if (cfg.valid) begin
      case (cfg.index)
        efd_pkg::REG_CRC_POLYNOMIAL:  regs.crc_polynomial  <= cfg.wdata;
        efd_pkg::REG_CRC_INITIAL:     regs.crc_initial     <= cfg.wdata;
        efd_pkg::REG_ESCAPE_LEADER:   regs.escape_leader   <= cfg.wdata[7:0];
        efd_pkg::REG_CODE_FOR_FF:     regs.code_for_ff     <= cfg.wdata[7:0];
        efd_pkg::REG_CODE_FOR_LEADER: regs.code_for_leader <= cfg.wdata[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/efd_crc_byte.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_crc_byte: one-byte CRC16 update
// Eight MSB-first bit steps with a programmable polynomial.
// ----------------------------------------------------------------------------
module efd_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  input  logic [15:0] polynomial,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] acc;
    acc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ polynomial;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    crc_out = acc;
  end

endmodule

>>> src/efd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_parser: frame state machine with escape decoding and CRC check
// Consumes one byte per step and offers at most one result word.
// ----------------------------------------------------------------------------
module efd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  efd_pkg::cfg_t    regs,
  output logic             res_valid,
  output efd_pkg::result_t res
);

  logic [3:0]  phase, phase_next;
  logic        escape_pending, escape_pending_next;
  logic [15:0] crc_acc, crc_acc_next;
  logic [7:0]  held_type, held_type_next;
  logic [15:0] held_sequence, held_sequence_next;
  logic [15:0] held_length, held_length_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [7:0]  held_crc_high, held_crc_high_next;

  logic [7:0]  dec_byte;
  logic        dec_have;
  logic        dec_err;
  logic        dec_esc_next;
  logic [7:0]  feed_byte;
  logic [15:0] crc_fed;
  logic [15:0] rcrc;
  logic [15:0] len_full;
  logic [15:0] remaining_dec;

  // Escape decoding of the current byte, used in payload and trailer phases.
  always_comb begin
    dec_byte     = rx_byte;
    dec_have     = 1'b0;
    dec_err      = 1'b0;
    dec_esc_next = 1'b0;
    if (escape_pending) begin
      if (rx_byte == regs.code_for_ff) begin
        dec_byte = 8'hFF;
        dec_have = 1'b1;
      end else if (rx_byte == regs.code_for_leader) begin
        dec_byte = regs.escape_leader;
        dec_have = 1'b1;
      end else begin
        dec_err = 1'b1;
      end
    end else if (rx_byte == regs.escape_leader) begin
      dec_esc_next = 1'b1;
    end else begin
      dec_have = 1'b1;
    end
  end

  assign feed_byte     = (phase == efd_pkg::PH_PAYLOAD) ? dec_byte : rx_byte;
  assign rcrc          = {held_crc_high, dec_byte};
  assign len_full      = {held_length[15:8], rx_byte};
  assign remaining_dec = bytes_remaining - 16'd1;

  efd_crc_byte u_crc (
    .crc_in     (crc_acc),
    .data       (feed_byte),
    .polynomial (regs.crc_polynomial),
    .crc_out    (crc_fed)
  );

  always_comb begin
    phase_next           = phase;
    escape_pending_next  = escape_pending;
    crc_acc_next         = crc_acc;
    held_type_next       = held_type;
    held_sequence_next   = held_sequence;
    held_length_next     = held_length;
    bytes_remaining_next = bytes_remaining;
    held_crc_high_next   = held_crc_high;

    res_valid          = 1'b0;
    res.kind           = efd_pkg::KIND_DATA;
    res.data_byte      = 8'h00;
    res.frame_type     = held_type;
    res.sequence_res   = held_sequence;
    res.payload_length = held_length;
    res.received_crc   = 16'h0000;
    res.status         = efd_pkg::ST_OK;

    case (phase)
      efd_pkg::PH_HUNT1: begin
        if (rx_byte == efd_pkg::SYNC_BYTE) phase_next = efd_pkg::PH_HUNT2;
      end
      efd_pkg::PH_HUNT2: begin
        if (rx_byte == efd_pkg::SYNC_BYTE) begin
          phase_next   = efd_pkg::PH_TYPE;
          crc_acc_next = regs.crc_initial;
        end else begin
          phase_next = efd_pkg::PH_HUNT1;
        end
      end
      efd_pkg::PH_TYPE: begin
        held_type_next = rx_byte;
        crc_acc_next   = crc_fed;
        phase_next     = efd_pkg::PH_SEQ_HI;
      end
      efd_pkg::PH_SEQ_HI: begin
        held_sequence_next = {rx_byte, 8'h00};
        crc_acc_next       = crc_fed;
        phase_next         = efd_pkg::PH_SEQ_LO;
      end
      efd_pkg::PH_SEQ_LO: begin
        held_sequence_next = {held_sequence[15:8], rx_byte};
        crc_acc_next       = crc_fed;
        phase_next         = efd_pkg::PH_LEN_HI;
      end
      efd_pkg::PH_LEN_HI: begin
        held_length_next = {rx_byte, 8'h00};
        crc_acc_next     = crc_fed;
        phase_next       = efd_pkg::PH_LEN_LO;
      end
      efd_pkg::PH_LEN_LO: begin
        held_length_next     = len_full;
        bytes_remaining_next = len_full;
        crc_acc_next         = crc_fed;
        escape_pending_next  = 1'b0;
        phase_next = (len_full == 16'h0000) ? efd_pkg::PH_CRC_HI : efd_pkg::PH_PAYLOAD;
      end
      efd_pkg::PH_PAYLOAD, efd_pkg::PH_CRC_HI, efd_pkg::PH_CRC_LO: begin
        escape_pending_next = dec_esc_next;
        if (dec_err) begin
          // A bad escape code ends the frame at once; the code byte is consumed.
          res_valid  = 1'b1;
          res.kind   = efd_pkg::KIND_END;
          res.status = efd_pkg::ST_ESC_ERR;
          phase_next = efd_pkg::PH_HUNT1;
        end else if (dec_have) begin
          if (phase == efd_pkg::PH_PAYLOAD) begin
            crc_acc_next         = crc_fed;
            bytes_remaining_next = remaining_dec;
            if (remaining_dec == 16'h0000) phase_next = efd_pkg::PH_CRC_HI;
            res_valid     = 1'b1;
            res.data_byte = dec_byte;
          end else if (phase == efd_pkg::PH_CRC_HI) begin
            held_crc_high_next = dec_byte;
            phase_next         = efd_pkg::PH_CRC_LO;
          end else begin
            res_valid        = 1'b1;
            res.kind         = efd_pkg::KIND_END;
            res.received_crc = rcrc;
            res.status = (rcrc == crc_acc) ? efd_pkg::ST_OK : efd_pkg::ST_CRC_BAD;
            phase_next = efd_pkg::PH_HUNT1;
          end
        end
      end
      default: begin
        phase_next          = efd_pkg::PH_HUNT1;
        escape_pending_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= efd_pkg::PH_HUNT1;
      escape_pending  <= 1'b0;
      crc_acc         <= efd_pkg::RST_CRC_INITIAL;
      held_type       <= 8'h00;
      held_sequence   <= 16'h0000;
      held_length     <= 16'h0000;
      bytes_remaining <= 16'h0000;
      held_crc_high   <= 8'h00;
    end else if (step) begin
      phase           <= phase_next;
      escape_pending  <= escape_pending_next;
      crc_acc         <= crc_acc_next;
      held_type       <= held_type_next;
      held_sequence   <= held_sequence_next;
      held_length     <= held_length_next;
      bytes_remaining <= bytes_remaining_next;
      held_crc_high   <= held_crc_high_next;
    end
  end

endmodule

>>> dv/escaped_frame_deframer_crc16_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_deframer_crc16_test: self-checking bench for the deframer
// Builds sync, header, escaped payload and trailer byte streams, tracks the
// parser state byte by byte to predict every payload and frame end word, and
// compares the result channel against it under random gaps and stalls.
// ----------------------------------------------------------------------------
module escaped_frame_deframer_crc16_test;

  typedef logic [7:0] byte_queue_t [$];
  typedef enum {FAULT_NONE, FAULT_CRC, FAULT_ESCAPE} fault_t;
  typedef enum {FF_RAW, FF_ESCAPED, FF_MIXED} ff_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  efd_rx_if  rx_ch ();
  efd_res_if res_ch ();
  efd_cfg_if cfg_ch ();

  escaped_frame_deframer_crc16 u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // Register copy and parser state as the bench sees them.
  efd_pkg::cfg_t settings;
  logic [3:0]    frame_phase;
  logic          escape_open;
  logic [15:0]   running_crc;
  logic [7:0]    hdr_type;
  logic [15:0]   hdr_sequence;
  logic [15:0]   hdr_length;
  logic [15:0]   payload_left;
  logic [7:0]    trailer_hi;

  efd_pkg::result_t expected_words [$];
  byte_queue_t      framed;
  int               mismatches = 0;
  int               frame_bytes_sent = 0;
  int               hold_request = 0;
  bit               steady = 1'b0;
  ff_style_t        ff_style = FF_MIXED;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [15:0] crc_step(logic [15:0] acc, logic [7:0] b,
                                           logic [15:0] poly);
    logic [15:0] a;
    a = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (a[15]) a = (a << 1) ^ poly;
      else a = a << 1;
    end
    return a;
  endfunction

  function automatic int pick_pause();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_result(logic k, logic [7:0] d, logic [15:0] rc,
                                       logic [1:0] st);
    efd_pkg::result_t w;
    w.kind           = k;
    w.data_byte      = d;
    w.frame_type     = hdr_type;
    w.sequence_res   = hdr_sequence;
    w.payload_length = hdr_length;
    w.received_crc   = rc;
    w.status         = st;
    expected_words.push_back(w);
  endfunction

  // Advances the parser copy by one accepted link byte.
  function automatic void track_rx_byte(logic [7:0] b);
    logic [7:0]  d;
    logic        have;
    logic [15:0] rc;
    have = 1'b0;
    d = 8'h00;
    case (frame_phase)
      efd_pkg::PH_HUNT1: if (b == efd_pkg::SYNC_BYTE) frame_phase = efd_pkg::PH_HUNT2;
      efd_pkg::PH_HUNT2: begin
        if (b == efd_pkg::SYNC_BYTE) begin
          frame_phase = efd_pkg::PH_TYPE;
          running_crc = settings.crc_initial;
        end else begin
          frame_phase = efd_pkg::PH_HUNT1;
        end
      end
      efd_pkg::PH_TYPE: begin
        hdr_type = b;
        running_crc = crc_step(running_crc, b, settings.crc_polynomial);
        frame_phase = efd_pkg::PH_SEQ_HI;
      end
      efd_pkg::PH_SEQ_HI: begin
        hdr_sequence = {b, 8'h00};
        running_crc = crc_step(running_crc, b, settings.crc_polynomial);
        frame_phase = efd_pkg::PH_SEQ_LO;
      end
      efd_pkg::PH_SEQ_LO: begin
        hdr_sequence[7:0] = b;
        running_crc = crc_step(running_crc, b, settings.crc_polynomial);
        frame_phase = efd_pkg::PH_LEN_HI;
      end
      efd_pkg::PH_LEN_HI: begin
        hdr_length = {b, 8'h00};
        running_crc = crc_step(running_crc, b, settings.crc_polynomial);
        frame_phase = efd_pkg::PH_LEN_LO;
      end
      efd_pkg::PH_LEN_LO: begin
        hdr_length[7:0] = b;
        running_crc = crc_step(running_crc, b, settings.crc_polynomial);
        payload_left = hdr_length;
        escape_open = 1'b0;
        frame_phase = (hdr_length == 16'd0) ? efd_pkg::PH_CRC_HI : efd_pkg::PH_PAYLOAD;
      end
      efd_pkg::PH_PAYLOAD, efd_pkg::PH_CRC_HI, efd_pkg::PH_CRC_LO: begin
        if (escape_open) begin
          escape_open = 1'b0;
          if (b == settings.code_for_ff) begin
            d = 8'hFF;
            have = 1'b1;
          end else if (b == settings.code_for_leader) begin
            d = settings.escape_leader;
            have = 1'b1;
          end else begin
            queue_result(efd_pkg::KIND_END, 8'h00, 16'h0000, efd_pkg::ST_ESC_ERR);
            frame_phase = efd_pkg::PH_HUNT1;
          end
        end else if (b == settings.escape_leader) begin
          escape_open = 1'b1;
        end else begin
          d = b;
          have = 1'b1;
        end
        if (have) begin
          case (frame_phase)
            efd_pkg::PH_PAYLOAD: begin
              running_crc = crc_step(running_crc, d, settings.crc_polynomial);
              payload_left = payload_left - 16'd1;
              if (payload_left == 16'd0) frame_phase = efd_pkg::PH_CRC_HI;
              queue_result(efd_pkg::KIND_DATA, d, 16'h0000, efd_pkg::ST_OK);
            end
            efd_pkg::PH_CRC_HI: begin
              trailer_hi = d;
              frame_phase = efd_pkg::PH_CRC_LO;
            end
            default: begin
              rc = {trailer_hi, d};
              queue_result(efd_pkg::KIND_END, 8'h00, rc,
                           (rc == running_crc) ? efd_pkg::ST_OK : efd_pkg::ST_CRC_BAD);
              frame_phase = efd_pkg::PH_HUNT1;
            end
          endcase
        end
      end
      default: begin
        frame_phase = efd_pkg::PH_HUNT1;
        escape_open = 1'b0;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    efd_pkg::result_t w;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("result word with none expected: kind %0d data 0x%0h status %0d",
               res_ch.kind, res_ch.data_byte, res_ch.status);
        mismatches++;
      end else begin
        w = expected_words.pop_front();
        check_field("kind", 16'(w.kind), 16'(res_ch.kind));
        check_field("data_byte", 16'(w.data_byte), 16'(res_ch.data_byte));
        check_field("frame_type", 16'(w.frame_type), 16'(res_ch.frame_type));
        check_field("sequence_res", w.sequence_res, res_ch.sequence_res);
        check_field("payload_length", w.payload_length, res_ch.payload_length);
        check_field("received_crc", w.received_crc, res_ch.received_crc);
        check_field("status", 16'(w.status), 16'(res_ch.status));
      end
    end
  end

  // Result receiver: random stalls, plus long hold-offs on request.
  initial begin
    int hold_left;
    int stall;
    hold_left = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        stall = pick_pause();
        if (stall == 0) begin
          res_ch.ready <= 1'b1;
        end else begin
          res_ch.ready <= 1'b0;
          hold_left = stall - 1;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_pause();
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    track_rx_byte(b);
  endtask

  // Lets every expected word drain and the pipeline empty.
  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [efd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      efd_pkg::REG_CRC_POLYNOMIAL:  settings.crc_polynomial  = val;
      efd_pkg::REG_CRC_INITIAL:     settings.crc_initial     = val;
      efd_pkg::REG_ESCAPE_LEADER:   settings.escape_leader   = val[7:0];
      efd_pkg::REG_CODE_FOR_FF:     settings.code_for_ff     = val[7:0];
      efd_pkg::REG_CODE_FOR_LEADER: settings.code_for_leader = val[7:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] poly, input logic [15:0] init,
                               input logic [7:0] leader, input logic [7:0] ff_code,
                               input logic [7:0] leader_code);
    wait_idle();
    write_reg(efd_pkg::REG_CRC_POLYNOMIAL, poly);
    write_reg(efd_pkg::REG_CRC_INITIAL, init);
    write_reg(efd_pkg::REG_ESCAPE_LEADER, {8'h00, leader});
    write_reg(efd_pkg::REG_CODE_FOR_FF, {8'h00, ff_code});
    write_reg(efd_pkg::REG_CODE_FOR_LEADER, {8'h00, leader_code});
  endtask

  // Appends one byte to the frame; the escape leader is always escaped, 0xFF as ff_style picks.
  function automatic void stuff_byte(logic [7:0] b);
    bit esc_ff;
    esc_ff = (ff_style == FF_ESCAPED) || (ff_style == FF_MIXED && $urandom_range(0, 1) == 1);
    if (b == settings.escape_leader) begin
      framed.push_back(settings.escape_leader);
      framed.push_back(settings.code_for_leader);
    end else if (b == 8'hFF && esc_ff) begin
      framed.push_back(settings.escape_leader);
      framed.push_back(settings.code_for_ff);
    end else begin
      framed.push_back(b);
    end
  endfunction

  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] fseq,
                            input logic [15:0] flen, input byte_queue_t body,
                            input fault_t fault);
    logic [15:0] crc;
    logic [7:0]  code;
    framed.delete();
    framed.push_back(efd_pkg::SYNC_BYTE);
    framed.push_back(efd_pkg::SYNC_BYTE);
    framed.push_back(ftype);
    framed.push_back(fseq[15:8]);
    framed.push_back(fseq[7:0]);
    framed.push_back(flen[15:8]);
    framed.push_back(flen[7:0]);
    crc = settings.crc_initial;
    for (int i = 2; i < 7; i++) crc = crc_step(crc, framed[i], settings.crc_polynomial);
    foreach (body[i]) begin
      crc = crc_step(crc, body[i], settings.crc_polynomial);
      stuff_byte(body[i]);
    end
    if (fault == FAULT_ESCAPE) begin
      do code = 8'($urandom_range(0, 255));
      while (code == settings.code_for_ff || code == settings.code_for_leader);
      framed.push_back(settings.escape_leader);
      framed.push_back(code);
    end else begin
      if (fault == FAULT_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
      stuff_byte(crc[15:8]);
      stuff_byte(crc[7:0]);
    end
    foreach (framed[i]) send_byte(framed[i]);
    frame_bytes_sent += framed.size();
  endtask

  // Line noise that never holds two sync bytes in a row nor ends on one.
  task automatic send_noise(input int n);
    logic [7:0] b;
    bit prev_ff;
    prev_ff = 1'b0;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) b = efd_pkg::SYNC_BYTE;
      if (b == efd_pkg::SYNC_BYTE && (prev_ff || i == n - 1)) b = 8'h00;
      prev_ff = (b == efd_pkg::SYNC_BYTE);
      send_byte(b);
    end
  endtask

  function automatic logic [7:0] payload_value();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'hFF;
    if (r == 1) return settings.escape_leader;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_frame();
    byte_queue_t body;
    fault_t      fault;
    int          len;
    int          r;
    int          cut;
    logic [15:0] declared;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 16);
    r = $urandom_range(0, 99);
    fault = (r < 70) ? FAULT_NONE : (r < 85) ? FAULT_CRC : FAULT_ESCAPE;
    declared = 16'(len);
    cut = len;
    if (fault == FAULT_ESCAPE) begin
      // A bad escape ends the frame early, so any declared length is cheap.
      if ($urandom_range(0, 1) == 1) declared = 16'($urandom_range(0, 65535));
      cut = (int'(declared) < 12) ? int'(declared) : 12;
      cut = $urandom_range(0, cut);
    end
    for (int i = 0; i < cut; i++) body.push_back(payload_value());
    send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), declared,
               body, fault);
  endtask

  task automatic test_directed();
    byte_queue_t body;
    // Broken sync: a lone sync byte followed by anything else.
    send_byte(efd_pkg::SYNC_BYTE);
    send_byte(8'h00);
    // Zero length with sync value as type and all-ones sequence, bad trailer.
    send_frame(8'hFF, 16'hFFFF, 16'd0, body, FAULT_CRC);
    // Raw 0xFF, an escaped leader and zero in the payload.
    ff_style = FF_RAW;
    body.push_back(8'hFF);
    body.push_back(settings.escape_leader);
    body.push_back(8'h00);
    send_frame(8'h00, 16'h0000, 16'd3, body, FAULT_NONE);
    ff_style = FF_MIXED;
    // Bad escape code right after the header of a maximum length frame.
    body.delete();
    send_frame(8'h01, 16'h1234, 16'hFFFF, body, FAULT_ESCAPE);
    wait_idle();
  endtask

  task automatic test_equal_codes();
    byte_queue_t body;
    // With both codes equal, the pair always decodes to 0xFF.
    apply_setting(efd_pkg::RST_CRC_POLYNOMIAL, efd_pkg::RST_CRC_INITIAL,
                  efd_pkg::RST_ESCAPE_LEADER, 8'h01, 8'h01);
    ff_style = FF_ESCAPED;
    body.push_back(8'hFF);
    body.push_back(efd_pkg::RST_ESCAPE_LEADER);
    send_frame(8'h5A, 16'h8000, 16'd2, body, FAULT_NONE);
    ff_style = FF_MIXED;
    wait_idle();
  endtask

  task automatic test_backpressure();
    byte_queue_t body;
    wait_idle();
    steady = 1'b1;
    hold_request = 300;
    for (int i = 0; i < 80; i++) body.push_back(payload_value());
    send_frame(8'h3C, 16'h0102, 16'd80, body, FAULT_NONE);
    steady = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int target;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_setting(efd_pkg::RST_CRC_POLYNOMIAL, efd_pkg::RST_CRC_INITIAL,
                         efd_pkg::RST_ESCAPE_LEADER, efd_pkg::RST_CODE_FOR_FF,
                         efd_pkg::RST_CODE_FOR_LEADER);
        1: apply_setting(16'hFFFF, 16'h0000, 8'h00, 8'hFF, 8'h00);
        2: apply_setting(16'h0000, 16'hFFFF, 8'hFF, 8'h00, 8'hFF);
        default: apply_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
      endcase
      steady = (p == 3);
      target = frame_bytes_sent + 150;
      while (frame_bytes_sent < target) begin
        if ($urandom_range(0, 99) < 15) send_noise($urandom_range(1, 6));
        else send_random_frame();
      end
      steady = 1'b0;
    end
    wait_idle();
  endtask

  initial begin
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    res_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = efd_pkg::REG_CRC_POLYNOMIAL;
    cfg_ch.wdata  = 16'h0000;
    settings.crc_polynomial  = efd_pkg::RST_CRC_POLYNOMIAL;
    settings.crc_initial     = efd_pkg::RST_CRC_INITIAL;
    settings.escape_leader   = efd_pkg::RST_ESCAPE_LEADER;
    settings.code_for_ff     = efd_pkg::RST_CODE_FOR_FF;
    settings.code_for_leader = efd_pkg::RST_CODE_FOR_LEADER;
    frame_phase  = efd_pkg::PH_HUNT1;
    escape_open  = 1'b0;
    running_crc  = efd_pkg::RST_CRC_INITIAL;
    hdr_type     = 8'h00;
    hdr_sequence = 16'h0000;
    hdr_length   = 16'h0000;
    payload_left = 16'h0000;
    trailer_hi   = 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_equal_codes();
    test_backpressure();
    test_random_traffic();

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/efd_pkg.sv
src/efd_if.sv
src/efd_cfg_regs.sv
src/efd_crc_byte.sv
src/efd_parser.sv
src/escaped_frame_deframer_crc16.sv
dv/escaped_frame_deframer_crc16_test.sv
